>>> sv/mkswl_pkg.sv
// shared constants, register indexes and controller/datapath interface types
package mkswl_pkg;

   localparam int NUM_KEYS        = 8;
   localparam int WINDOW_SLOTS    = 8;
   localparam int KEY_BITS        = $clog2(NUM_KEYS);
   localparam int SLOT_BITS       = $clog2(WINDOW_SLOTS);
   localparam int FILL_BITS       = $clog2(WINDOW_SLOTS + 1);
   localparam int STAMP_ADDR_BITS = KEY_BITS + SLOT_BITS;
   localparam int STAMP_DEPTH     = NUM_KEYS * WINDOW_SLOTS;

   localparam int KEY_COUNT_W   = 4;
   localparam int DAILY_W       = 16;
   localparam int WLIM_W        = 4;
   localparam int TICKS_W       = 32;
   localparam int TIME_W        = 32;
   localparam int GRANT_INDEX_W = 3;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET    = 4'd5;
   localparam logic [DAILY_W-1:0]     DAILY_LIMIT_RESET  = 16'd800;
   localparam logic [WLIM_W-1:0]      WINDOW_LIMIT_RESET = 4'd8;
   localparam logic [TICKS_W-1:0]     WINDOW_TICKS_RESET = 32'd60;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KEY_COUNT    = 2'd0,
      REG_DAILY_LIMIT  = 2'd1,
      REG_WINDOW_LIMIT = 2'd2,
      REG_WINDOW_TICKS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic deny;
      logic advance;
      logic pop;
      logic grant;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic capped;
      logic fill_zero;
      logic expired;
      logic room;
      logic last;
   } dp_status_type;

endpackage

>>> sv/mkswl_ram.sv
// generic single-port ram with registered read
module mkswl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/mkswl_ctrl.sv
// controller state machine: walks credentials, expires stamps, grants or denies
module mkswl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  mkswl_pkg::dp_status_type status,
   output mkswl_pkg::dp_cmd_type    cmd
);
   import mkswl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CHECK  = 4'b0010,
      S_READ   = 4'b0100,
      S_EXPIRE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (status.count_zero) begin
                  cmd.deny = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (status.capped) begin
               if (status.last) begin
                  cmd.deny = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            // oldest stamp address is presented, data lands next cycle
            state_in = S_EXPIRE;
         end
         S_EXPIRE: begin
            if (!status.fill_zero && status.expired) begin
               cmd.pop  = 1'b1;
               state_in = S_READ;
            end else if (status.room) begin
               cmd.grant = 1'b1;
               state_in  = S_IDLE;
            end else if (status.last) begin
               cmd.deny = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> sv/mkswl_dp.sv
// datapath: config registers, per-credential counters, stamp ram and result register
module mkswl_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [mkswl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mkswl_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [mkswl_pkg::TIME_W-1:0]          req_now_time,
   input  mkswl_pkg::dp_cmd_type                 cmd,
   output mkswl_pkg::dp_status_type              status,
   output logic                                  rsp_valid,
   output logic                                  rsp_granted,
   output logic [mkswl_pkg::GRANT_INDEX_W-1:0]   rsp_grant_index
);
   import mkswl_pkg::*;

   // configuration
   logic [KEY_COUNT_W-1:0] key_count_ff, key_count_in;
   logic [DAILY_W-1:0]     daily_limit_ff, daily_limit_in;
   logic [WLIM_W-1:0]      window_limit_ff, window_limit_in;
   logic [TICKS_W-1:0]     window_ticks_ff, window_ticks_in;

   // per-credential state
   logic [KEY_BITS-1:0]  next_pointer_ff, next_pointer_in;
   logic [DAILY_W-1:0]   life_ff [NUM_KEYS];
   logic [DAILY_W-1:0]   life_in [NUM_KEYS];
   logic [SLOT_BITS-1:0] head_ff [NUM_KEYS];
   logic [SLOT_BITS-1:0] head_in [NUM_KEYS];
   logic [FILL_BITS-1:0] fill_ff [NUM_KEYS];
   logic [FILL_BITS-1:0] fill_in [NUM_KEYS];

   // scan state
   logic [KEY_BITS-1:0] cur_key_ff, cur_key_in;
   logic [KEY_BITS-1:0] scan_ff, scan_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   // result
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_granted_ff, rsp_granted_in;
   logic [GRANT_INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic [KEY_COUNT_W-1:0]     count_eff;
   logic [WLIM_W-1:0]          wlim_eff;
   logic [KEY_BITS-1:0]        start_key;
   logic [KEY_BITS-1:0]        wrap_key;
   logic [SLOT_BITS-1:0]       head_sel;
   logic [FILL_BITS-1:0]       fill_sel;
   logic [DAILY_W-1:0]         life_sel;
   logic [TIME_W-1:0]          stamp_rdata;
   logic [TIME_W-1:0]          age;
   logic [SLOT_BITS-1:0]       ram_slot;
   logic [STAMP_ADDR_BITS-1:0] ram_addr;

   assign count_eff = (key_count_ff > KEY_COUNT_W'(NUM_KEYS)) ?
                      KEY_COUNT_W'(NUM_KEYS) : key_count_ff;
   assign wlim_eff  = (window_limit_ff > WLIM_W'(WINDOW_SLOTS)) ?
                      WLIM_W'(WINDOW_SLOTS) : window_limit_ff;

   // a pointer left beyond a lowered key count restarts at credential 0
   assign start_key = (KEY_COUNT_W'(next_pointer_ff) >= count_eff) ? '0 : next_pointer_ff;
   assign wrap_key  = ((KEY_COUNT_W'(cur_key_ff) + KEY_COUNT_W'(1)) == count_eff) ?
                      '0 : cur_key_ff + KEY_BITS'(1);

   assign head_sel = head_ff[cur_key_ff];
   assign fill_sel = fill_ff[cur_key_ff];
   assign life_sel = life_ff[cur_key_ff];

   // on grant write the slot after the newest stamp, otherwise read the oldest
   assign ram_slot = cmd.grant ? head_sel + SLOT_BITS'(fill_sel) : head_sel;
   assign ram_addr = {cur_key_ff, ram_slot};

   mkswl_ram #(
      .WIDTH (TIME_W),
      .DEPTH (STAMP_DEPTH)
   ) u_stamp_ram (
      .clock (clock),
      .we    (cmd.grant),
      .addr  (ram_addr),
      .wdata (now_ff),
      .rdata (stamp_rdata)
   );

   assign age = now_ff - stamp_rdata;

   assign status.count_zero = (count_eff == '0);
   assign status.capped     = (life_sel >= daily_limit_ff);
   assign status.fill_zero  = (fill_sel == '0);
   assign status.expired    = (age >= window_ticks_ff);
   assign status.room       = (WLIM_W'(fill_sel) < wlim_eff);
   assign status.last       = ((KEY_COUNT_W'(scan_ff) + KEY_COUNT_W'(1)) == count_eff);

   always_comb begin
      key_count_in    = key_count_ff;
      daily_limit_in  = daily_limit_ff;
      window_limit_in = window_limit_ff;
      window_ticks_in = window_ticks_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_KEY_COUNT:    key_count_in    = csr_data[KEY_COUNT_W-1:0];
            REG_DAILY_LIMIT:  daily_limit_in  = csr_data[DAILY_W-1:0];
            REG_WINDOW_LIMIT: window_limit_in = csr_data[WLIM_W-1:0];
            REG_WINDOW_TICKS: window_ticks_in = csr_data[TICKS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      next_pointer_in = next_pointer_ff;
      life_in         = life_ff;
      head_in         = head_ff;
      fill_in         = fill_ff;
      cur_key_in      = cur_key_ff;
      scan_in         = scan_ff;
      now_in          = now_ff;
      rsp_valid_in    = 1'b0;
      rsp_granted_in  = rsp_granted_ff;
      rsp_index_in    = rsp_index_ff;

      if (cmd.load) begin
         now_in          = req_now_time;
         cur_key_in      = start_key;
         next_pointer_in = start_key;
         scan_in         = '0;
      end
      if (cmd.advance) begin
         cur_key_in = wrap_key;
         scan_in    = scan_ff + KEY_BITS'(1);
      end
      if (cmd.pop) begin
         head_in[cur_key_ff] = head_sel + SLOT_BITS'(1);
         fill_in[cur_key_ff] = fill_sel - FILL_BITS'(1);
      end
      if (cmd.grant) begin
         life_in[cur_key_ff] = life_sel + DAILY_W'(1);
         fill_in[cur_key_ff] = fill_sel + FILL_BITS'(1);
         next_pointer_in     = wrap_key;
         rsp_valid_in        = 1'b1;
         rsp_granted_in      = 1'b1;
         rsp_index_in        = GRANT_INDEX_W'(cur_key_ff);
      end
      if (cmd.deny) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = 1'b0;
         rsp_index_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff    <= KEY_COUNT_RESET;
         daily_limit_ff  <= DAILY_LIMIT_RESET;
         window_limit_ff <= WINDOW_LIMIT_RESET;
         window_ticks_ff <= WINDOW_TICKS_RESET;
         next_pointer_ff <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            life_ff[k] <= '0;
            head_ff[k] <= '0;
            fill_ff[k] <= '0;
         end
         cur_key_ff      <= '0;
         scan_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         key_count_ff    <= key_count_in;
         daily_limit_ff  <= daily_limit_in;
         window_limit_ff <= window_limit_in;
         window_ticks_ff <= window_ticks_in;
         next_pointer_ff <= next_pointer_in;
         life_ff         <= life_in;
         head_ff         <= head_in;
         fill_ff         <= fill_in;
         cur_key_ff      <= cur_key_in;
         scan_ff         <= scan_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_grant_index = rsp_index_ff;

endmodule

>>> sv/multi_key_sliding_window_limiter_core.sv
// Multi-credential sliding-window grant limiter, top level.
// A request is a transaction taken when start is high and busy is low; it
// carries req_now_time. Exactly one result comes back per request as a
// one-cycle pulse on rsp_valid with rsp_granted and rsp_grant_index.
// Credentials are scanned round-robin from a rotating pointer; capped ones
// are skipped, old stamps of the others are dropped from a per-credential
// ring in the stamp ram, and the first one with window room is granted.
// A denial on a zero key count is decided in the idle state. Otherwise each
// scanned credential is checked against its cap; one that is not capped has
// its oldest stamp read and tested, one stamp ram read per expired stamp,
// before its window room is checked. The result appears the cycle after the
// decision. busy stays high until the decision, and the next request may be
// taken while the result is shown.
// The receiver cannot stall: results must be taken on the strobe cycle.
// Reset restores register defaults, clears the pointer, lifetime counts
// and ring heads and fills; stamp ram contents are left as they are.
// Configuration writes on csr_we/csr_index/csr_data take effect at once
// and must be made only while no request is in flight; the core does not enforce it.
module multi_key_sliding_window_limiter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mkswl_pkg::TIME_W-1:0]        req_now_time,
   output logic                                rsp_valid,
   output logic                                rsp_granted,
   output logic [mkswl_pkg::GRANT_INDEX_W-1:0] rsp_grant_index,
   input  logic                                csr_we,
   input  logic [mkswl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mkswl_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mkswl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mkswl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   mkswl_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_now_time    (req_now_time),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_granted     (rsp_granted),
      .rsp_grant_index (rsp_grant_index)
   );

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the multi-key sliding-window limiter core
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mkswl_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int EXPECT_DEPTH = 4096;
   localparam int OPS_DEPTH    = 4096;
   localparam int ROUNDS       = 10;
   localparam int ROUND_ITEMS  = 93;

   typedef enum logic {OP_REQ, OP_CSR} op_kind_type;

   typedef struct {
      op_kind_type       kind;
      csr_index_type     reg_sel;
      logic [31:0]       value;
      int                gap;
   } op_entry_type;

   typedef struct packed {
      logic                     granted;
      logic [GRANT_INDEX_W-1:0] key_idx;
   } grant_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [TIME_W-1:0]        req_now_time = '0;
   logic                     rsp_valid;
   logic                     rsp_granted;
   logic [GRANT_INDEX_W-1:0] rsp_grant_index;
   logic                     csr_we = 1'b0;
   csr_index_type            csr_index = REG_KEY_COUNT;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   // shadow of the limiter: configuration and per-credential state
   logic [KEY_COUNT_W-1:0] cfg_keys;
   logic [DAILY_W-1:0]     cfg_daily;
   logic [WLIM_W-1:0]      cfg_wlim;
   logic [TICKS_W-1:0]     cfg_ticks;
   logic [KEY_BITS-1:0]    scan_ptr;
   logic [DAILY_W-1:0]     life_cnt [NUM_KEYS];
   logic [TIME_W-1:0]      stamps [STAMP_DEPTH];
   logic [SLOT_BITS-1:0]   ring_head [NUM_KEYS];
   logic [FILL_BITS-1:0]   ring_fill [NUM_KEYS];

   // pending operations, filled by the stimulus and drained by the driver
   op_entry_type  ops_list [OPS_DEPTH];
   int            ops_wr = 0;
   int            ops_rd = 0;
   op_entry_type  cur_op;
   bit            have_cur = 1'b0;
   int            gap_left = 0;
   grant_rsp_type grant_expect [EXPECT_DEPTH];
   int unsigned   issued_cnt = 0;
   int unsigned   rsp_seen = 0;
   int unsigned   cycle_cnt = 0;
   int            fault_cnt = 0;
   int            n_granted = 0;
   int            n_denied = 0;
   int            csr_writes = 0;

   multi_key_sliding_window_limiter_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_now_time    (req_now_time),
      .rsp_valid       (rsp_valid),
      .rsp_granted     (rsp_granted),
      .rsp_grant_index (rsp_grant_index),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic grant_rsp_type predict_grant(input logic [TIME_W-1:0] now);
      grant_rsp_type     res;
      int                keys_used, room, k, slot;
      logic [TIME_W-1:0] age;
      res = '0;
      keys_used = (cfg_keys > NUM_KEYS) ? NUM_KEYS : cfg_keys;
      room = (cfg_wlim > WINDOW_SLOTS) ? WINDOW_SLOTS : cfg_wlim;
      if (keys_used == 0) return res;
      // key count may have dropped below the pointer since the last request
      if (scan_ptr >= keys_used) scan_ptr = '0;
      for (int n = 0; n < keys_used; n++) begin
         k = scan_ptr;
         scan_ptr = KEY_BITS'((scan_ptr + 1) % keys_used);
         if (life_cnt[k] >= cfg_daily) continue;
         // drop stamps whose wrapped age has reached the window
         while (ring_fill[k] != 0) begin
            age = now - stamps[k * WINDOW_SLOTS + ring_head[k]];
            if (age < cfg_ticks) break;
            ring_head[k] = SLOT_BITS'((ring_head[k] + 1) % WINDOW_SLOTS);
            ring_fill[k] = ring_fill[k] - 1'b1;
         end
         if (ring_fill[k] < room) begin
            slot = (ring_head[k] + ring_fill[k]) % WINDOW_SLOTS;
            stamps[k * WINDOW_SLOTS + slot] = now;
            ring_fill[k] = ring_fill[k] + 1'b1;
            life_cnt[k] = life_cnt[k] + 1'b1;
            res.granted = 1'b1;
            res.key_idx = GRANT_INDEX_W'(k);
            return res;
         end
      end
      return res;
   endfunction

   function automatic void note_csr(input csr_index_type sel, input logic [31:0] val);
      case (sel)
         REG_KEY_COUNT:    cfg_keys = val[KEY_COUNT_W-1:0];
         REG_DAILY_LIMIT:  cfg_daily = val[DAILY_W-1:0];
         REG_WINDOW_LIMIT: cfg_wlim = val[WLIM_W-1:0];
         REG_WINDOW_TICKS: cfg_ticks = val[TICKS_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic void add_op(input op_entry_type e);
      ops_list[ops_wr % OPS_DEPTH] = e;
      ops_wr++;
   endfunction

   function automatic void queue_req(input logic [31:0] now, input int gap);
      op_entry_type e;
      e.kind = OP_REQ;
      e.reg_sel = REG_KEY_COUNT;
      e.value = now;
      e.gap = gap;
      add_op(e);
   endfunction

   function automatic void queue_csr(input csr_index_type sel, input logic [31:0] val);
      op_entry_type e;
      int           w;
      case (sel)
         REG_KEY_COUNT:    w = KEY_COUNT_W;
         REG_DAILY_LIMIT:  w = DAILY_W;
         REG_WINDOW_LIMIT: w = WLIM_W;
         default:          w = TICKS_W;
      endcase
      e.kind = OP_CSR;
      e.reg_sel = sel;
      e.value = val;
      e.gap = 0;
      // unused upper data bits get random junk half the time
      if ($urandom_range(0, 1) == 1) e.value = val | ($urandom() << w);
      add_op(e);
   endfunction

   task automatic flag_fault(input string msg);
      fault_cnt++;
      if (fault_cnt <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic wait_drain();
      while (ops_rd != ops_wr || have_cur || start || busy || issued_cnt != rsp_seen)
         @(posedge clock);
   endtask

   // driver: requests and register writes in queue order
   always @(posedge clock) begin : driver
      logic took, nx_start, nx_we;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         issued_cnt <= 0;
         have_cur = 1'b0;
         cfg_keys = KEY_COUNT_RESET;
         cfg_daily = DAILY_LIMIT_RESET;
         cfg_wlim = WINDOW_LIMIT_RESET;
         cfg_ticks = WINDOW_TICKS_RESET;
         scan_ptr = '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            life_cnt[k] = '0;
            ring_head[k] = '0;
            ring_fill[k] = '0;
         end
      end else begin
         took = start && !busy;
         nx_start = start && !took;
         nx_we = 1'b0;
         if (took) begin
            grant_expect[issued_cnt % EXPECT_DEPTH] = predict_grant(req_now_time);
            issued_cnt <= issued_cnt + 1;
         end
         if (!nx_start && !have_cur && ops_rd != ops_wr) begin
            cur_op = ops_list[ops_rd % OPS_DEPTH];
            ops_rd++;
            have_cur = 1'b1;
            gap_left = cur_op.gap;
         end
         if (!nx_start && have_cur) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cur_op.kind == OP_REQ) begin
               nx_start = 1'b1;
               req_now_time <= cur_op.value;
               have_cur = 1'b0;
            end else if (!took && !busy && issued_cnt == rsp_seen) begin
               // registers only change with no transaction in flight
               nx_we = 1'b1;
               csr_index <= cur_op.reg_sel;
               csr_data <= cur_op.value;
               note_csr(cur_op.reg_sel, cur_op.value);
               csr_writes++;
               have_cur = 1'b0;
            end
         end
         start <= nx_start;
         csr_we <= nx_we;
      end
   end

   // monitor: results pair up with requests in order
   always @(posedge clock) begin : monitor
      grant_rsp_type want;
      if (reset) begin
         rsp_seen <= 0;
      end else if (rsp_valid) begin
         rsp_seen <= rsp_seen + 1;
         if (rsp_seen >= issued_cnt) begin
            flag_fault($sformatf("result with no request outstanding: granted %0b key %0d",
                                 rsp_granted, rsp_grant_index));
         end else begin
            want = grant_expect[rsp_seen % EXPECT_DEPTH];
            if (rsp_granted !== want.granted || rsp_grant_index !== want.key_idx)
               flag_fault($sformatf("request %0d: expected granted %0b key %0d, got %0b key %0d",
                                    rsp_seen, want.granted, want.key_idx,
                                    rsp_granted, rsp_grant_index));
            if (want.granted) n_granted++;
            else n_denied++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d results seen",
                  cycle_cnt, rsp_seen, issued_cnt);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0]        walk, ticks, val;
      logic [DAILY_W-1:0] least;
      int                 r, step_max;
      bit                 calm;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // defaults, both time extremes
      queue_req(32'h0000_0000, 0);
      queue_req(32'hFFFF_FFFF, 0);
      // pointer left beyond the new key count, windows straddling the time wrap
      queue_csr(REG_KEY_COUNT, 2);
      queue_csr(REG_WINDOW_LIMIT, 2);
      queue_csr(REG_WINDOW_TICKS, 10);
      queue_req(32'hFFFF_FFF8, 0);
      queue_req(32'hFFFF_FFF9, 0);
      queue_req(32'hFFFF_FFFA, 2);
      queue_req(32'hFFFF_FFFB, 0);
      queue_req(32'hFFFF_FFFC, 0);
      queue_req(32'h0000_0002, 5);
      queue_req(32'h0000_0003, 0);
      // zero window expires everything
      queue_csr(REG_WINDOW_TICKS, 0);
      queue_req(32'h0000_0003, 0);
      queue_req(32'h0000_0003, 0);
      // zero window limit denies
      queue_csr(REG_WINDOW_LIMIT, 0);
      queue_req(32'h0000_0004, 0);
      // oversized key count and window limit are clamped
      queue_csr(REG_WINDOW_LIMIT, 15);
      queue_csr(REG_KEY_COUNT, 15);
      queue_csr(REG_WINDOW_TICKS, 32'hFFFF_FFFF);
      queue_req(32'h0000_0005, 0);
      queue_req(32'h0000_0006, 1);
      queue_req(32'h0000_0007, 0);
      // no credentials at all
      queue_csr(REG_KEY_COUNT, 0);
      queue_req(32'h0000_0008, 0);
      // zero lifetime cap, then the widest one, then a tight one
      queue_csr(REG_KEY_COUNT, 8);
      queue_csr(REG_DAILY_LIMIT, 0);
      queue_req(32'h0000_0009, 0);
      queue_csr(REG_DAILY_LIMIT, 16'hFFFF);
      queue_req(32'h8000_0000, 0);
      queue_csr(REG_DAILY_LIMIT, 2);
      queue_req(32'h5555_5555, 0);
      queue_req(32'hAAAA_AAAA, 0);
      queue_req(32'h0000_000A, 0);
      queue_req(32'h0000_000B, 0);
      queue_csr(REG_KEY_COUNT, 1);
      queue_req(32'h0000_000C, 0);
      wait_drain();

      for (int round = 0; round < ROUNDS; round++) begin
         calm = ($urandom_range(0, 3) == 0);

         r = $urandom_range(0, 99);
         if (r < 8) val = 0;
         else if (r < 16) val = $urandom_range(NUM_KEYS + 1, 15);
         else if (r < 40) val = NUM_KEYS;
         else val = $urandom_range(1, NUM_KEYS);
         queue_csr(REG_KEY_COUNT, val);

         // lifetime counts never clear, so the cap tracks the lowest count
         least = life_cnt[0];
         for (int k = 1; k < NUM_KEYS; k++)
            if (life_cnt[k] < least) least = life_cnt[k];
         r = $urandom_range(0, 99);
         if (r < 8) val = 0;
         else if (r < 18) val = 16'hFFFF;
         else if (r < 24) val = $urandom_range(0, 16'hFFFF);
         else val = (least > 16'hFFFF - 40) ? 16'hFFFF : least + $urandom_range(1, 30);
         queue_csr(REG_DAILY_LIMIT, val);

         r = $urandom_range(0, 99);
         if (r < 8) val = 0;
         else if (r < 16) val = $urandom_range(WINDOW_SLOTS + 1, 15);
         else val = $urandom_range(1, WINDOW_SLOTS);
         queue_csr(REG_WINDOW_LIMIT, val);

         r = $urandom_range(0, 99);
         if (r < 60) ticks = $urandom_range(1, 64);
         else if (r < 70) ticks = 0;
         else if (r < 78) ticks = 1;
         else if (r < 86) ticks = 32'hFFFF_FFFF;
         else ticks = $urandom();
         queue_csr(REG_WINDOW_TICKS, ticks);

         if (ticks >= 1 && ticks <= 64) step_max = ticks / $urandom_range(1, 8) + 1;
         else step_max = $urandom_range(1, 8);
         if ($urandom_range(0, 3) == 0) walk = 32'hFFFF_FFFF - $urandom_range(0, 300);
         else walk = $urandom();

         // mostly advancing time, some steps back and some wild jumps
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 85) walk = walk + $urandom_range(0, step_max);
            else if (r < 93) walk = walk - $urandom_range(1, 50);
            else walk = $urandom();
            queue_req(walk, pick_gap(calm));
         end
         wait_drain();
      end

      repeat (200) @(posedge clock);
      $display("%0d requests checked: %0d granted, %0d denied, %0d faults",
               issued_cnt, n_granted, n_denied, fault_cnt);
      $display("%0d register writes over a directed pass and %0d random settings",
               csr_writes, ROUNDS);
      if (fault_cnt == 0 && issued_cnt == rsp_seen) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
